@@ sv/lrts_pkg.sv @@
// Shared types and constants for the least-run-time thread scheduler.
// Used by lrts_cell and least_run_time_thread_scheduler_unit.
package lrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    localparam int CMD_W   = 3;
    localparam int ID_W    = 16;
    localparam int US_W    = 20;
    localparam int TIME_W  = 32;
    localparam int ORDER_W = 32;
    localparam int STAT_W  = 2;

    localparam int IN_BITS  = CMD_W + ID_W + US_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + ID_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_RUNNING = 2'd2;

    // Candidate handed from cell to cell along the chain
    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  run_time;
        logic [ORDER_W-1:0] order;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    user_id;
        logic               free_found;
        logic [SLOT_W-1:0]  free_slot;
    } cand_t;

    // Update controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic               create;
        logic [SLOT_W-1:0]  create_slot;
        logic [ID_W-1:0]    create_id;
        logic [ORDER_W-1:0] create_order;
        logic               charge;
        logic               reorder;
        logic               release_slot;
        logic [SLOT_W-1:0]  run_slot;
        logic [US_W-1:0]    elapsed;
        logic [ORDER_W-1:0] new_order;
    } ctl_t;

endpackage

@@ sv/lrts_cell.sv @@
// One thread slot of the scheduler chain: holds the slot state and
// registers the running best candidate and lowest free slot onward.
// Depends on lrts_pkg.
module lrts_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lrts_pkg::SLOT_W-1:0] slot_idx,
    input  lrts_pkg::ctl_t              ctl,
    input  lrts_pkg::cand_t             cand_in,
    output lrts_pkg::cand_t             cand_out
);

    logic                         used_reg;
    logic [lrts_pkg::ID_W-1:0]    user_id_reg;
    logic [lrts_pkg::TIME_W-1:0]  run_time_reg;
    logic [lrts_pkg::ORDER_W-1:0] order_reg;
    lrts_pkg::cand_t              cand_reg;
    lrts_pkg::cand_t              cand_next;
    logic [lrts_pkg::TIME_W:0]    sum;
    logic                         is_running;
    logic                         take;

    assign is_running = (ctl.run_slot == slot_idx);
    assign sum = {1'b0, run_time_reg}
               + {{(lrts_pkg::TIME_W + 1 - lrts_pkg::US_W){1'b0}}, ctl.elapsed};

    // Slot state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctl.create && ctl.create_slot == slot_idx)
        begin
            used_reg <= 1'b1;
        end
        else if (ctl.release_slot && is_running)
        begin
            used_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.create && ctl.create_slot == slot_idx)
        begin
            user_id_reg  <= ctl.create_id;
            run_time_reg <= '0;
            order_reg    <= ctl.create_order;
        end
        else
        begin
            // saturating charge of elapsed time
            if (ctl.charge && is_running)
            begin
                run_time_reg <= sum[lrts_pkg::TIME_W] ? '1 : sum[lrts_pkg::TIME_W-1:0];
            end
            if (ctl.reorder && is_running)
            begin
                order_reg <= ctl.new_order;
            end
        end
    end

    // Compare with incoming candidate; run-time ties go to the lower order, full ties keep lower index
    always_comb
    begin
        take = used_reg &&
               (!cand_in.found ||
                run_time_reg < cand_in.run_time ||
                (run_time_reg == cand_in.run_time && order_reg < cand_in.order));
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found    = 1'b1;
            cand_next.run_time = run_time_reg;
            cand_next.order    = order_reg;
            cand_next.slot     = slot_idx;
            cand_next.user_id  = user_id_reg;
        end
        if (!cand_in.free_found && !used_reg)
        begin
            cand_next.free_found = 1'b1;
            cand_next.free_slot  = slot_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

@@ sv/least_run_time_thread_scheduler_unit.sv @@
// Least-run-time thread scheduler: sequencer plus a chain of slot cells.
// From input beat to result beat: lock, unlock, undecoded commands and commands with nothing
// running go straight to the result; tick or yield while locked charge, then give the result;
// create scans the chain; unlocked tick or yield and any exit charge, then scan the chain, one
// cell per cycle. One command at a time; the next beat is taken the cycle after the result issues.
// Reset (rst_n, async, low) clears slot used bits, running state, lock, counter. Uses lrts_cell.
module least_run_time_thread_scheduler_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrts_pkg::IN_W-1:0]   s_tdata,  // cmd, thread_id, elapsed_us
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lrts_pkg::OUT_W-1:0]  m_tdata   // running_valid, running_id, status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHARGE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t                           state_reg;
    logic [lrts_pkg::CMD_W-1:0]       cmd_reg;
    logic [lrts_pkg::ID_W-1:0]        tid_reg;
    logic [lrts_pkg::US_W-1:0]        us_reg;
    logic [lrts_pkg::CNT_W-1:0]       cnt_reg;
    logic [lrts_pkg::ORDER_W-1:0]     counter_reg;
    logic [lrts_pkg::SLOT_W-1:0]      run_slot_reg;
    logic                             run_flag_reg;
    logic [lrts_pkg::ID_W-1:0]        run_id_reg;
    logic                             locked_reg;
    logic [lrts_pkg::STAT_W-1:0]      status_reg;
    logic                             m_valid_reg;
    logic [lrts_pkg::OUT_W-1:0]       m_data_reg;

    logic [lrts_pkg::CMD_W-1:0]       in_cmd;
    logic                             is_sched;
    logic                             scan_done;
    lrts_pkg::ctl_t                   ctl;
    lrts_pkg::cand_t                  chain [lrts_pkg::MAX_THREADS+1];

    assign in_cmd    = s_tdata[lrts_pkg::CMD_W-1:0];
    assign is_sched  = (cmd_reg == lrts_pkg::CMD_TICK) || (cmd_reg == lrts_pkg::CMD_YIELD);
    assign scan_done = (cnt_reg == lrts_pkg::CNT_W'(lrts_pkg::MAX_THREADS));
    assign s_tready  = (state_reg == S_IDLE);

    // Empty candidate enters the head of the chain
    assign chain[0] = '0;

    // Row of slot cells
    for (genvar g = 0; g < lrts_pkg::MAX_THREADS; g++)
    begin : g_cell
        lrts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (lrts_pkg::SLOT_W'(g)),
            .ctl      (ctl),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1])
        );
    end

    // Broadcast controls to the cells
    always_comb
    begin
        ctl              = '0;
        ctl.run_slot     = run_slot_reg;
        ctl.elapsed      = us_reg;
        ctl.new_order    = counter_reg;
        ctl.create_slot  = chain[lrts_pkg::MAX_THREADS].free_slot;
        ctl.create_id    = tid_reg;
        ctl.create_order = counter_reg;
        if (state_reg == S_CHARGE)
        begin
            ctl.charge       = is_sched;
            ctl.reorder      = is_sched && !locked_reg;
            ctl.release_slot = (cmd_reg == lrts_pkg::CMD_EXIT);
        end
        if (state_reg == S_SCAN && scan_done && cmd_reg == lrts_pkg::CMD_CREATE)
        begin
            ctl.create = chain[lrts_pkg::MAX_THREADS].free_found;
        end
    end

    // Command sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            tid_reg      <= '0;
            us_reg       <= '0;
            cnt_reg      <= '0;
            counter_reg  <= '0;
            run_slot_reg <= '0;
            run_flag_reg <= 1'b0;
            run_id_reg   <= '0;
            locked_reg   <= 1'b0;
            status_reg   <= lrts_pkg::ST_OK;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            // result beat taken; S_RESULT reloads it itself
            if (m_valid_reg && m_tready && state_reg != S_RESULT)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= in_cmd;
                        tid_reg    <= s_tdata[lrts_pkg::CMD_W +: lrts_pkg::ID_W];
                        us_reg     <= s_tdata[lrts_pkg::CMD_W + lrts_pkg::ID_W +: lrts_pkg::US_W];
                        cnt_reg    <= '0;
                        case (in_cmd)
                            lrts_pkg::CMD_CREATE:
                            begin
                                status_reg <= lrts_pkg::ST_OK;
                                state_reg  <= S_SCAN;
                            end
                            lrts_pkg::CMD_TICK, lrts_pkg::CMD_YIELD, lrts_pkg::CMD_EXIT:
                            begin
                                if (run_flag_reg)
                                begin
                                    status_reg <= lrts_pkg::ST_OK;
                                    state_reg  <= S_CHARGE;
                                end
                                else
                                begin
                                    status_reg <= lrts_pkg::ST_NO_RUNNING;
                                    state_reg  <= S_RESULT;
                                end
                            end
                            lrts_pkg::CMD_LOCK:
                            begin
                                locked_reg <= 1'b1;
                                status_reg <= lrts_pkg::ST_OK;
                                state_reg  <= S_RESULT;
                            end
                            lrts_pkg::CMD_UNLOCK:
                            begin
                                locked_reg <= 1'b0;
                                status_reg <= lrts_pkg::ST_OK;
                                state_reg  <= S_RESULT;
                            end
                            default:
                            begin
                                status_reg <= lrts_pkg::ST_OK;
                                state_reg  <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_CHARGE:
                begin
                    // cells charge, reorder or release this cycle
                    if (is_sched && !locked_reg)
                    begin
                        counter_reg <= counter_reg + 1'b1;
                    end
                    if (is_sched && locked_reg)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!scan_done)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                        if (cmd_reg == lrts_pkg::CMD_CREATE)
                        begin
                            if (!chain[lrts_pkg::MAX_THREADS].free_found)
                            begin
                                status_reg <= lrts_pkg::ST_FULL;
                            end
                            else
                            begin
                                counter_reg <= counter_reg + 1'b1;
                                if (!run_flag_reg)
                                begin
                                    run_flag_reg <= 1'b1;
                                    run_slot_reg <= chain[lrts_pkg::MAX_THREADS].free_slot;
                                    run_id_reg   <= tid_reg;
                                end
                            end
                        end
                        else
                        begin
                            run_flag_reg <= chain[lrts_pkg::MAX_THREADS].found;
                            run_slot_reg <= chain[lrts_pkg::MAX_THREADS].found ?
                                            chain[lrts_pkg::MAX_THREADS].slot : '0;
                            run_id_reg   <= chain[lrts_pkg::MAX_THREADS].found ?
                                            chain[lrts_pkg::MAX_THREADS].user_id : '0;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{(lrts_pkg::OUT_W - lrts_pkg::OUT_BITS){1'b0}},
                                        status_reg, run_id_reg, run_flag_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
